>>> rtl/core/qmr_pkg.sv
// quaternion multiply / renormalize: shared types, constants and microcode rom
// used by qmr_seq, qmr_dpath and quaternion_multiply_renormalize; no dependencies
package qmr_pkg;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned DataW     = 32;
  localparam int unsigned WideW     = 64;
  localparam int unsigned StepW     = 5;

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_MUL      = 2'd1;
  localparam logic [1:0] REQ_MUL_NORM = 2'd2;

  localparam logic [StepW-1:0] STEP_MUL    = 5'd0;
  localparam logic [StepW-1:0] STEP_COMMIT = 5'd29;
  localparam logic [StepW-1:0] STEP_LOAD   = 5'd30;
  localparam logic [StepW-1:0] STEP_HOLD   = 5'd31;

  typedef struct packed {
    logic        [1:0]       req_type;
    logic signed [DataW-1:0] in_w;
    logic signed [DataW-1:0] in_x;
    logic signed [DataW-1:0] in_y;
    logic signed [DataW-1:0] in_z;
  } qmr_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_w;
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
  } qmr_out_t;

  typedef enum logic [3:0] {
    SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3,
    SRC_O0, SRC_O1, SRC_O2, SRC_O3,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_K
  } qmr_src_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ONE_MINUS, ACC_HALF
  } qmr_acc_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_P3, DST_K
  } qmr_dst_e;

  typedef enum logic [1:0] {
    CMT_NONE, CMT_PROD, CMT_LOAD, CMT_HOLD
  } qmr_cmt_e;

  typedef enum logic {
    ST_IDLE, ST_RUN
  } qmr_state_e;

  typedef struct packed {
    qmr_src_e a_sel;
    qmr_src_e b_sel;
    qmr_acc_e acc_op;
    qmr_dst_e wb_dst;
    qmr_cmt_e commit;
  } qmr_ctrl_t;

  typedef struct packed {
    qmr_ctrl_t ctrl;
    logic      jump_nr;
    logic      last;
  } qmr_uword_t;

  localparam qmr_ctrl_t CTRL_NOP = '{a_sel: SRC_Q0, b_sel: SRC_O0, acc_op: ACC_HOLD,
                                      wb_dst: DST_NONE, commit: CMT_NONE};

  function automatic qmr_uword_t uw(qmr_src_e a, qmr_src_e b, qmr_acc_e op,
                                    qmr_dst_e dst, qmr_cmt_e cmt, logic jnr);
    qmr_uword_t w;
    w.ctrl.a_sel  = a;
    w.ctrl.b_sel  = b;
    w.ctrl.acc_op = op;
    w.ctrl.wb_dst = dst;
    w.ctrl.commit = cmt;
    w.jump_nr     = jnr;
    w.last        = (cmt != CMT_NONE);
    return w;
  endfunction

  // multiplier issues in step n, accumulator consumes the product in step n+1,
  // rounded sum is written back in the step after the last accumulate
  function automatic qmr_uword_t ucode(logic [StepW-1:0] step);
    qmr_uword_t w;
    case (step)
      5'd0:    w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_NONE, CMT_NONE, 1'b0);
      5'd1:    w = uw(SRC_Q1, SRC_O1, ACC_LOAD,      DST_NONE, CMT_NONE, 1'b0);
      5'd2:    w = uw(SRC_Q2, SRC_O2, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd3:    w = uw(SRC_Q3, SRC_O3, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd4:    w = uw(SRC_Q0, SRC_O1, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd5:    w = uw(SRC_Q1, SRC_O0, ACC_LOAD,      DST_P0,   CMT_NONE, 1'b0);
      5'd6:    w = uw(SRC_Q2, SRC_O3, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd7:    w = uw(SRC_Q3, SRC_O2, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd8:    w = uw(SRC_Q0, SRC_O2, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd9:    w = uw(SRC_Q1, SRC_O3, ACC_LOAD,      DST_P1,   CMT_NONE, 1'b0);
      5'd10:   w = uw(SRC_Q2, SRC_O0, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd11:   w = uw(SRC_Q3, SRC_O1, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd12:   w = uw(SRC_Q0, SRC_O3, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd13:   w = uw(SRC_Q1, SRC_O2, ACC_LOAD,      DST_P2,   CMT_NONE, 1'b0);
      5'd14:   w = uw(SRC_Q2, SRC_O1, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd15:   w = uw(SRC_Q3, SRC_O0, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd16:   w = uw(SRC_P0, SRC_P0, ACC_ADD,       DST_NONE, CMT_NONE, 1'b0);
      5'd17:   w = uw(SRC_P1, SRC_P1, ACC_ONE_MINUS, DST_P3,   CMT_NONE, 1'b1);
      5'd18:   w = uw(SRC_P2, SRC_P2, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd19:   w = uw(SRC_P3, SRC_P3, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd20:   w = uw(SRC_Q0, SRC_O0, ACC_SUB,       DST_NONE, CMT_NONE, 1'b0);
      5'd21:   w = uw(SRC_Q0, SRC_O0, ACC_HALF,      DST_NONE, CMT_NONE, 1'b0);
      5'd22:   w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_K,    CMT_NONE, 1'b0);
      5'd23:   w = uw(SRC_P0, SRC_K,  ACC_HOLD,      DST_NONE, CMT_NONE, 1'b0);
      5'd24:   w = uw(SRC_P1, SRC_K,  ACC_LOAD,      DST_NONE, CMT_NONE, 1'b0);
      5'd25:   w = uw(SRC_P2, SRC_K,  ACC_LOAD,      DST_P0,   CMT_NONE, 1'b0);
      5'd26:   w = uw(SRC_P3, SRC_K,  ACC_LOAD,      DST_P1,   CMT_NONE, 1'b0);
      5'd27:   w = uw(SRC_Q0, SRC_O0, ACC_LOAD,      DST_P2,   CMT_NONE, 1'b0);
      5'd28:   w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_P3,   CMT_NONE, 1'b0);
      5'd29:   w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_NONE, CMT_PROD, 1'b0);
      5'd30:   w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_NONE, CMT_LOAD, 1'b0);
      5'd31:   w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_NONE, CMT_HOLD, 1'b0);
      default: w = uw(SRC_Q0, SRC_O0, ACC_HOLD,      DST_NONE, CMT_HOLD, 1'b0);
    endcase
    return w;
  endfunction

  function automatic logic [StepW-1:0] entry_step(logic [1:0] req);
    logic [StepW-1:0] s;
    case (req)
      REQ_LOAD:              s = STEP_LOAD;
      REQ_MUL, REQ_MUL_NORM: s = STEP_MUL;
      default:               s = STEP_HOLD;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/qmr_seq.sv
// qmr microsequencer: step counter, control rom lookup, conditional jump
// depends on qmr_pkg
module qmr_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           req_i,
  input  logic                 out_free_i,
  output logic                 ready_o,
  output logic                 done_o,
  output qmr_pkg::qmr_ctrl_t   ctrl_o
);

  qmr_pkg::qmr_state_e            state_q, state_d;
  logic [qmr_pkg::StepW-1:0]      step_q, step_d;
  logic                           renorm_q, renorm_d;
  qmr_pkg::qmr_uword_t            uword;

  assign uword = qmr_pkg::ucode(step_q);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    renorm_d = renorm_q;
    case (state_q)
      qmr_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d  = qmr_pkg::ST_RUN;
          step_d   = qmr_pkg::entry_step(req_i);
          renorm_d = (req_i == qmr_pkg::REQ_MUL_NORM);
        end
      end
      qmr_pkg::ST_RUN: begin
        if (uword.last) begin
          if (out_free_i) begin
            state_d = qmr_pkg::ST_IDLE;
          end
        end else if (uword.jump_nr && !renorm_q) begin
          step_d = qmr_pkg::STEP_COMMIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: begin
        state_d = qmr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ready_o = 1'b0;
    done_o  = 1'b0;
    ctrl_o  = qmr_pkg::CTRL_NOP;
    case (state_q)
      qmr_pkg::ST_IDLE: begin
        ready_o = 1'b1;
      end
      qmr_pkg::ST_RUN: begin
        ctrl_o = uword.ctrl;
        done_o = uword.last && out_free_i;
        if (uword.last && !out_free_i) begin
          ctrl_o.commit = qmr_pkg::CMT_NONE;
        end
      end
      default: begin
        ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= qmr_pkg::ST_IDLE;
      step_q   <= '0;
      renorm_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      renorm_q <= renorm_d;
    end
  end

endmodule

>>> rtl/core/qmr_dpath.sv
// qmr datapath: register file, shared 32x32 multiplier, 64-bit accumulator,
// rounding write-back and orientation commit; depends on qmr_pkg
module qmr_dpath #(
  parameter int unsigned FracBits = qmr_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  qmr_pkg::qmr_in_t   op_i,
  input  qmr_pkg::qmr_ctrl_t ctrl_i,
  output qmr_pkg::qmr_out_t  q_o
);

  localparam logic [qmr_pkg::WideW-1:0] OneWide = 64'(1) << (2 * FracBits);
  localparam logic [qmr_pkg::WideW-1:0] HalfLsb = 64'(1) << (FracBits - 1);
  localparam logic [qmr_pkg::DataW-1:0] OneQ    = 32'(1) << FracBits;

  logic [qmr_pkg::DataW-1:0]        q_q [4];
  logic [qmr_pkg::DataW-1:0]        o_q [4];
  logic [qmr_pkg::DataW-1:0]        p_q [4];
  logic [qmr_pkg::DataW-1:0]        k_q;
  logic [qmr_pkg::WideW-1:0]        prod_q;
  logic [qmr_pkg::WideW-1:0]        acc_q, acc_d;
  logic signed [qmr_pkg::DataW-1:0] a_op, b_op;
  logic signed [qmr_pkg::WideW-1:0] prod_d;
  logic [qmr_pkg::WideW-1:0]        rnd_sum, rnd_sh;
  logic [qmr_pkg::DataW-1:0]        wb_val;

  function automatic logic [qmr_pkg::DataW-1:0] pick(
    qmr_pkg::qmr_src_e sel,
    logic [qmr_pkg::DataW-1:0] q0, logic [qmr_pkg::DataW-1:0] q1,
    logic [qmr_pkg::DataW-1:0] q2, logic [qmr_pkg::DataW-1:0] q3,
    logic [qmr_pkg::DataW-1:0] o0, logic [qmr_pkg::DataW-1:0] o1,
    logic [qmr_pkg::DataW-1:0] o2, logic [qmr_pkg::DataW-1:0] o3,
    logic [qmr_pkg::DataW-1:0] p0, logic [qmr_pkg::DataW-1:0] p1,
    logic [qmr_pkg::DataW-1:0] p2, logic [qmr_pkg::DataW-1:0] p3,
    logic [qmr_pkg::DataW-1:0] k);
    logic [qmr_pkg::DataW-1:0] v;
    case (sel)
      qmr_pkg::SRC_Q0: v = q0;
      qmr_pkg::SRC_Q1: v = q1;
      qmr_pkg::SRC_Q2: v = q2;
      qmr_pkg::SRC_Q3: v = q3;
      qmr_pkg::SRC_O0: v = o0;
      qmr_pkg::SRC_O1: v = o1;
      qmr_pkg::SRC_O2: v = o2;
      qmr_pkg::SRC_O3: v = o3;
      qmr_pkg::SRC_P0: v = p0;
      qmr_pkg::SRC_P1: v = p1;
      qmr_pkg::SRC_P2: v = p2;
      qmr_pkg::SRC_P3: v = p3;
      qmr_pkg::SRC_K:  v = k;
      default:         v = '0;
    endcase
    return v;
  endfunction

  assign a_op = pick(ctrl_i.a_sel, q_q[0], q_q[1], q_q[2], q_q[3],
                     o_q[0], o_q[1], o_q[2], o_q[3],
                     p_q[0], p_q[1], p_q[2], p_q[3], k_q);
  assign b_op = pick(ctrl_i.b_sel, q_q[0], q_q[1], q_q[2], q_q[3],
                     o_q[0], o_q[1], o_q[2], o_q[3],
                     p_q[0], p_q[1], p_q[2], p_q[3], k_q);

  assign prod_d = a_op * b_op;

  always_comb begin
    case (ctrl_i.acc_op)
      qmr_pkg::ACC_HOLD:      acc_d = acc_q;
      qmr_pkg::ACC_LOAD:      acc_d = prod_q;
      qmr_pkg::ACC_ADD:       acc_d = acc_q + prod_q;
      qmr_pkg::ACC_SUB:       acc_d = acc_q - prod_q;
      qmr_pkg::ACC_ONE_MINUS: acc_d = OneWide - prod_q;
      qmr_pkg::ACC_HALF:      acc_d = {acc_q[qmr_pkg::WideW-1], acc_q[qmr_pkg::WideW-1:1]}
                                      + OneWide;
      default:                acc_d = acc_q;
    endcase
  end

  // round half up, drop fraction bits, wrap to 32
  assign rnd_sum = acc_q + HalfLsb;
  assign rnd_sh  = rnd_sum >> FracBits;
  assign wb_val  = rnd_sh[qmr_pkg::DataW-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ld_i) begin
      o_q[0] <= op_i.in_w;
      o_q[1] <= op_i.in_x;
      o_q[2] <= op_i.in_y;
      o_q[3] <= op_i.in_z;
    end
    case (ctrl_i.wb_dst)
      qmr_pkg::DST_P0: p_q[0] <= wb_val;
      qmr_pkg::DST_P1: p_q[1] <= wb_val;
      qmr_pkg::DST_P2: p_q[2] <= wb_val;
      qmr_pkg::DST_P3: p_q[3] <= wb_val;
      qmr_pkg::DST_K:  k_q    <= wb_val;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= OneQ;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else begin
      case (ctrl_i.commit)
        qmr_pkg::CMT_PROD: begin
          q_q <= p_q;
        end
        qmr_pkg::CMT_LOAD: begin
          q_q <= o_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign q_o.out_w = q_q[0];
  assign q_o.out_x = q_q[1];
  assign q_o.out_y = q_q[2];
  assign q_o.out_z = q_q[3];

endmodule

>>> rtl/core/quaternion_multiply_renormalize.sv
// quaternion_multiply_renormalize: orientation update by quaternion product
// top level; uses qmr_pkg, qmr_seq and qmr_dpath
//
// holds an orientation quaternion (four signed Q2.30 words, identity after
// reset) and updates it once per input beat. req_type selects load (take the
// operand as the new orientation), multiply (orientation * operand) or multiply
// followed by first-order renormalization; the unused code leaves it as is.
// every input beat returns exactly one output beat carrying the new orientation.
// in_ready_o is high only while the sequencer is idle; one item is in flight.
// a microcoded program runs all arithmetic through one 32x32 multiplier and a
// 64-bit accumulator, one product per cycle; program length by request type:
//   load or unused code: 1 step
//   multiply:            19 steps
//   multiply+renorm:     30 steps
// in_ready_o returns the cycle the output appears and the next beat is accepted
// at the end of it. if the receiver stalls, the finished output beat waits in
// the orientation register; the next item may be accepted and computed, but
// holds at its final step until the output beat is taken. reset clears the
// sequencer and output valid and sets the orientation to identity; no clearing
// pass is needed.
module quaternion_multiply_renormalize #(
  parameter int unsigned FracBits = qmr_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmr_pkg::qmr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmr_pkg::qmr_out_t out_data_o
);

  logic               in_fire;
  logic               out_free;
  logic               done;
  logic               out_valid_q, out_valid_d;
  qmr_pkg::qmr_ctrl_t ctrl;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  qmr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .req_i      (in_data_i.req_type),
    .out_free_i (out_free),
    .ready_o    (in_ready_o),
    .done_o     (done),
    .ctrl_o     (ctrl)
  );

  qmr_dpath #(
    .FracBits (FracBits)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (in_fire),
    .op_i   (in_data_i),
    .ctrl_i (ctrl),
    .q_o    (out_data_o)
  );

  always_comb begin
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("input accepted while sequencer already busy");

  a_idle_on_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o
  ) else $error("result raised without sequencer returning to idle");

  a_no_commit_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !done
  ) else $error("commit while previous result still pending");

endmodule
